// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the load/store unit RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked check, switched off while reset is high.
`define LSU_ASSERT_RST(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
// Clocked check that also holds during reset.
`define LSU_ASSERT_CLK(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define LSU_ASSERT_RST(lbl, clk_s, rst_s, prop, msg)
`define LSU_ASSERT_CLK(lbl, clk_s, prop, msg)
`endif
`endif

// ===== rtl/lsu_pkg.sv =====
// Types, codes and helper functions of the load/store unit.
// Depends on nothing; used by lsu_mem_array and the top level of the unit.
package lsu_pkg;

  // Access type codes as carried on the request channel.
  typedef enum logic [2:0] {
    ACC_LB  = 3'd0,
    ACC_LH  = 3'd1,
    ACC_LW  = 3'd2,
    ACC_LBU = 3'd3,
    ACC_LHU = 3'd4,
    ACC_SB  = 3'd5,
    ACC_SH  = 3'd6,
    ACC_SW  = 3'd7
  } acc_type_t;

  // Command from the control logic to the memory array.
  typedef struct packed {
    logic       rd;      // read four bytes from the read address
    logic       wr;      // write the low bytes at the write address
    logic [2:0] nbytes;  // number of bytes to write: 1, 2 or 4
  } mem_cmd_t;

  // True for the three store codes.
  function automatic logic is_store(input acc_type_t t);
    logic s;
    case (t)
      ACC_SB, ACC_SH, ACC_SW: s = 1'b1;
      default:                s = 1'b0;
    endcase
    return s;
  endfunction

  // Number of bytes a store writes.
  function automatic logic [2:0] store_len(input acc_type_t t);
    logic [2:0] n;
    case (t)
      ACC_SB:  n = 3'd1;
      ACC_SH:  n = 3'd2;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

  // Sign or zero extension of the bytes read for a load.
  function automatic logic [31:0] load_extend(input logic [31:0] w, input acc_type_t t);
    logic [31:0] v;
    case (t)
      ACC_LB:  v = {{24{w[7]}}, w[7:0]};
      ACC_LH:  v = {{16{w[15]}}, w[15:0]};
      ACC_LBU: v = {24'h0, w[7:0]};
      ACC_LHU: v = {16'h0, w[15:0]};
      default: v = w;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/lsu_if.sv =====
// Valid/ready channel interfaces of the load/store unit.
// Depends on nothing; instantiated around the top level.
interface lsu_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [2:0]  access_type;
  logic [15:0] address;
  logic [31:0] store_data;

  modport source (output valid, op, access_type, address, store_data, input ready);
  modport sink (input valid, op, access_type, address, store_data, output ready);
endinterface

interface lsu_rsp_if;
  logic        valid;
  logic        ready;
  logic        done_res;
  logic        almost_done;
  logic [31:0] load_value;

  modport source (output valid, done_res, almost_done, load_value, input ready);
  modport sink (input valid, done_res, almost_done, load_value, output ready);
endinterface

// ===== rtl/lsu_lane_ram.sv =====
// One byte lane of the data memory: one write port, one registered read port.
// Depends on nothing.
module lsu_lane_ram #(
  parameter int ROW_BITS = 14
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ROW_BITS-1:0] waddr,
  input  logic [7:0]          wdata,
  input  logic                re,
  input  logic [ROW_BITS-1:0] raddr,
  output logic [7:0]          rdata
);

  logic [7:0] mem [2**ROW_BITS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lsu_mem_array.sv =====
// Byte-addressed little-endian data memory built from four byte lanes.
// Depends on lsu_pkg and lsu_lane_ram. Clears itself row by row after reset.
module lsu_mem_array #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lsu_pkg::mem_cmd_t    cmd,
  input  logic [ADDR_BITS-1:0] rd_addr,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [31:0]          wr_data,
  output logic [31:0]          rd_word,
  output logic                 busy
);

  localparam int RowW = ADDR_BITS - 2;

  logic [RowW-1:0] clr_row;
  logic [1:0]      rd_off;
  logic [7:0]      lane_q [4];

  // Clearing sweep: one row of all four lanes per cycle after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == {RowW{1'b1}}) begin
        busy <= 1'b0;
      end
    end
  end

  // Byte offset of the last read, used to put the lanes back in order.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_off <= rd_addr[1:0];
    end
  end

  // Each lane takes the row of the access, or the next row where the access
  // has wrapped past lane three.
  for (genvar j = 0; j < 4; j++) begin : g_lane
    localparam logic [1:0] Lane = 2'(j);
    logic [1:0]      wr_idx;
    logic            lane_we;
    logic [RowW-1:0] lane_waddr;
    logic [7:0]      lane_wdata;
    logic [RowW-1:0] lane_raddr;

    assign wr_idx = Lane - wr_addr[1:0];
    assign lane_we = busy | (cmd.wr & ({1'b0, wr_idx} < cmd.nbytes));
    assign lane_waddr = busy ? clr_row
                             : wr_addr[ADDR_BITS-1:2] + RowW'(Lane < wr_addr[1:0]);
    assign lane_wdata = busy ? 8'h00 : wr_data[8*wr_idx +: 8];
    assign lane_raddr = rd_addr[ADDR_BITS-1:2] + RowW'(Lane < rd_addr[1:0]);

    lsu_lane_ram #(
      .ROW_BITS(RowW)
    ) u_ram (
      .clk  (clk),
      .we   (lane_we),
      .waddr(lane_waddr),
      .wdata(lane_wdata),
      .re   (cmd.rd),
      .raddr(lane_raddr),
      .rdata(lane_q[j])
    );
  end

  // Byte i of the word comes from the lane that holds address + i.
  always_comb begin
    logic [1:0] idx;
    for (int i = 0; i < 4; i++) begin
      idx = rd_off + 2'(i);
      rd_word[8*i +: 8] = lane_q[idx];
    end
  end

endmodule

// ===== rtl/load_store_unit_fixed_latency.sv =====
// Top level of the fixed-latency load/store unit: tick counter, pending access.
// Depends on lsu_pkg, lsu_if, lsu_mem_array and assert_macros.svh.
//
//   channel  | direction | carries
//   ---------+-----------+-------------------------------------------------
//   req      | in        | op, access_type, address, store_data
//   rsp      | out       | done_res, almost_done, load_value
//
// One request is taken per cycle while req.ready is high; its response is
// registered and shows in the next cycle. A request is taken while no response
// is pending or the pending response is taken. The memory is read on an issue
// request through its registered read port, the only memory access before the
// completing tick; stores write on that tick. After reset the memory is cleared
// row by row while req.ready stays low.
// A stalled response holds req.ready low until rsp.ready returns.
`include "assert_macros.svh"

module load_store_unit_fixed_latency #(
  parameter int LATENCY       = 3,
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  lsu_req_if.sink    req,
  lsu_rsp_if.source  rsp
);

  localparam int CntW = $clog2(LATENCY + 1);
  localparam int ExtW = MEM_ADDR_BITS + 16;
  localparam logic [CntW-1:0] LatC = CntW'(LATENCY);
  localparam logic [CntW-1:0] LatM1 = CntW'(LATENCY - 1);
  localparam logic [CntW:0] LatW = (CntW + 1)'(LATENCY);

  logic [CntW-1:0]           tick_count;
  lsu_pkg::acc_type_t        pend_type;
  logic [15:0]               pend_addr;
  logic [31:0]               pend_data;
  logic [31:0]               result_value;
  logic                      rsp_valid;

  logic                      req_acc;
  logic                      issue;
  logic                      complete;
  logic                      mem_busy;
  logic [31:0]               rd_word;
  lsu_pkg::mem_cmd_t         cmd;
  logic [ExtW-1:0]           rd_ext;
  logic [ExtW-1:0]           wr_ext;

  // Request handshake.
  assign req.ready = !mem_busy && (!rsp_valid || rsp.ready);
  assign req_acc = req.valid && req.ready;
  assign issue = req_acc && req.op;
  assign complete = req_acc && !req.op && (tick_count == LatM1);

  // Memory command: read at issue, write on the completing tick of a store.
  assign rd_ext = ExtW'(req.address);
  assign wr_ext = ExtW'(pend_addr);
  always_comb begin
    cmd.rd = issue;
    cmd.wr = complete && lsu_pkg::is_store(pend_type);
    cmd.nbytes = lsu_pkg::store_len(pend_type);
  end

  lsu_mem_array #(
    .ADDR_BITS(MEM_ADDR_BITS)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .rd_addr(rd_ext[MEM_ADDR_BITS-1:0]),
    .wr_addr(wr_ext[MEM_ADDR_BITS-1:0]),
    .wr_data(pend_data),
    .rd_word(rd_word),
    .busy   (mem_busy)
  );

  // Tick counter, pending access and held load value.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= LatC;
      pend_type    <= lsu_pkg::ACC_LB;
      pend_addr    <= '0;
      pend_data    <= '0;
      result_value <= '0;
    end else if (issue) begin
      tick_count <= '0;
      pend_type  <= lsu_pkg::acc_type_t'(req.access_type);
      pend_addr  <= req.address;
      pend_data  <= req.store_data;
    end else if (req_acc && (tick_count != LatC)) begin
      tick_count <= tick_count + 1'b1;
      if (complete && !lsu_pkg::is_store(pend_type)) begin
        result_value <= lsu_pkg::load_extend(rd_word, pend_type);
      end
    end
  end

  // Response register; the payload follows the state, which only moves on
  // a taken request.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_acc) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.done_res = (tick_count == LatC);
  assign rsp.almost_done = (({1'b0, tick_count} + 1'b1) == LatW);
  assign rsp.load_value = result_value;

  // Checks on the counter and the handshake interplay.
  `LSU_ASSERT_RST(a_tick_range, clk, rst, tick_count <= LatC, "tick counter beyond latency")
  `LSU_ASSERT_RST(a_issue_clears, clk, rst, issue |=> (tick_count == '0), "issue did not clear counter")
  `LSU_ASSERT_RST(a_complete_done, clk, rst, complete |=> (rsp.valid && rsp.done_res), "completion not reported")
  `LSU_ASSERT_RST(a_clear_blocks, clk, rst, mem_busy |-> !req.ready, "request taken during memory clear")

endmodule
